// File: sv/rcfb_pkg.sv
// types and constants shared by the rectangle copy and fill blitter
// no dependencies
`default_nettype none

package rcfb_pkg;

  localparam int OP_W    = 2;
  localparam int COORD_W = 6;
  localparam int SIZE_W  = 7;
  localparam int PIX_W   = 32;

  typedef enum logic [OP_W-1:0] {
    OP_FILL  = 2'd0,
    OP_COPY  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_PIX_WR,
    ST_PIX_RD,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: sv/rcfb_if.sv
// command and response channel interfaces of the blitter
// depends on rcfb_pkg
`default_nettype none

interface rcfb_cmd_if;
  logic                             valid;
  logic                             ready;
  rcfb_pkg::op_t                    operation;
  logic [rcfb_pkg::COORD_W-1:0]     dest_x;
  logic [rcfb_pkg::COORD_W-1:0]     dest_y;
  logic [rcfb_pkg::COORD_W-1:0]     src_x;
  logic [rcfb_pkg::COORD_W-1:0]     src_y;
  logic [rcfb_pkg::SIZE_W-1:0]      rect_width;
  logic [rcfb_pkg::SIZE_W-1:0]      rect_height;
  logic [rcfb_pkg::PIX_W-1:0]       pixel_value;

  modport source (
    output valid, operation, dest_x, dest_y, src_x, src_y, rect_width, rect_height,
           pixel_value,
    input  ready
  );
  modport sink (
    input  valid, operation, dest_x, dest_y, src_x, src_y, rect_width, rect_height,
           pixel_value,
    output ready
  );
endinterface

interface rcfb_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [rcfb_pkg::PIX_W-1:0] read_value;
  logic                       out_of_bounds;

  modport source (output valid, read_value, out_of_bounds, input ready);
  modport sink   (input valid, read_value, out_of_bounds, output ready);
endinterface

`default_nettype wire

// File: sv/rcfb_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rcfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/rect_copy_fill_blitter.sv
// rectangle copy and fill blitter over a pixel store held in one ram
// depends on rcfb_pkg, rcfb_if, rcfb_ram
//
//   channel  role  moves
//   cmd      sink  one command per transaction
//   rsp      src   one result per transaction
//
// fill writes one pixel a cycle; copy reads each source pixel from the ram, then writes it
// write and read pixel pass through ST_PIX_WR or ST_PIX_RD to ST_DONE; refused or empty commands go straight to ST_DONE
// the single ram port pair sets this pacing
// after reset a clearing pass that writes zero to every pixel holds cmd not ready
// a finished result waits in the output register while the next command is taken
`default_nettype none

module rect_copy_fill_blitter #(
  parameter int FB_COLUMNS = 64,
  parameter int FB_ROWS    = 64,
  parameter int PIXEL_BITS = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  rcfb_cmd_if.sink   cmd,
  rcfb_rsp_if.source rsp
);

  localparam int DEPTH = FB_COLUMNS * FB_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = rcfb_pkg::SIZE_W;

  rcfb_pkg::state_t state, state_next;

  logic [AW-1:0]         clr_addr;
  rcfb_pkg::op_t         op_q;
  logic                  oob_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic                  row_up, col_up;
  logic [CW-1:0]         cur_x, cur_y, cur_sx, cur_sy;
  logic [CW-1:0]         x0, sx0;
  logic [CW-1:0]         w_q;
  logic [CW-1:0]         col_left, row_left;

  logic                  out_valid;
  logic [rcfb_pkg::PIX_W-1:0] out_value;
  logic                  out_oob;
  logic                  out_free;

  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [PIXEL_BITS-1:0] ram_wdata, rd_data;
  logic                  step, last, clr_last, accept;

  logic                  is_rect, empty, dst_fit, src_fit, px_fit, oob_now, skip;
  logic                  row_up_now, col_up_now;

  function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    pix_addr = AW'(32'(y) * 32'(FB_COLUMNS) + 32'(x));
  endfunction

  // command decode at accept
  always_comb begin
    is_rect = (cmd.operation == rcfb_pkg::OP_FILL) || (cmd.operation == rcfb_pkg::OP_COPY);
    empty   = (cmd.rect_width == '0) || (cmd.rect_height == '0);
    dst_fit = (32'(cmd.dest_x) + 32'(cmd.rect_width) <= 32'(FB_COLUMNS)) &&
              (32'(cmd.dest_y) + 32'(cmd.rect_height) <= 32'(FB_ROWS));
    src_fit = (32'(cmd.src_x) + 32'(cmd.rect_width) <= 32'(FB_COLUMNS)) &&
              (32'(cmd.src_y) + 32'(cmd.rect_height) <= 32'(FB_ROWS));
    px_fit  = (32'(cmd.dest_x) < 32'(FB_COLUMNS)) && (32'(cmd.dest_y) < 32'(FB_ROWS));
    case (cmd.operation)
      rcfb_pkg::OP_FILL: oob_now = !empty && !dst_fit;
      rcfb_pkg::OP_COPY: oob_now = !empty && (!dst_fit || !src_fit);
      default:           oob_now = !px_fit;
    endcase
    skip       = oob_now || (is_rect && empty);
    row_up_now = (cmd.operation != rcfb_pkg::OP_COPY) || (cmd.src_y >= cmd.dest_y);
    col_up_now = (cmd.operation != rcfb_pkg::OP_COPY) || (cmd.src_x >= cmd.dest_x);
  end

  assign accept   = cmd.valid && cmd.ready;
  assign last     = (col_left == CW'(1)) && (row_left == CW'(1));
  assign clr_last = (clr_addr == AW'(DEPTH - 1));
  assign out_free = !out_valid || rsp.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rcfb_pkg::ST_CLEAR:   if (clr_last) state_next = rcfb_pkg::ST_IDLE;
      rcfb_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          if (skip) begin
            state_next = rcfb_pkg::ST_DONE;
          end else begin
            case (cmd.operation)
              rcfb_pkg::OP_FILL:  state_next = rcfb_pkg::ST_FILL;
              rcfb_pkg::OP_COPY:  state_next = rcfb_pkg::ST_COPY_RD;
              rcfb_pkg::OP_WRITE: state_next = rcfb_pkg::ST_PIX_WR;
              default:            state_next = rcfb_pkg::ST_PIX_RD;
            endcase
          end
        end
      end
      rcfb_pkg::ST_FILL:    if (last) state_next = rcfb_pkg::ST_DONE;
      rcfb_pkg::ST_COPY_RD: state_next = rcfb_pkg::ST_COPY_WR;
      rcfb_pkg::ST_COPY_WR: state_next = last ? rcfb_pkg::ST_DONE : rcfb_pkg::ST_COPY_RD;
      rcfb_pkg::ST_PIX_WR:  state_next = rcfb_pkg::ST_DONE;
      rcfb_pkg::ST_PIX_RD:  state_next = rcfb_pkg::ST_DONE;
      rcfb_pkg::ST_DONE:    if (out_free) state_next = rcfb_pkg::ST_IDLE;
      default:              state_next = rcfb_pkg::ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd.ready = (state == rcfb_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    step      = 1'b0;
    ram_waddr = pix_addr(cur_x, cur_y);
    ram_raddr = pix_addr(cur_x, cur_y);
    ram_wdata = pix_q;
    case (state)
      rcfb_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      rcfb_pkg::ST_FILL: begin
        ram_we = 1'b1;
        step   = 1'b1;
      end
      rcfb_pkg::ST_COPY_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pix_addr(cur_sx, cur_sy);
      end
      rcfb_pkg::ST_COPY_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rd_data;
        step      = 1'b1;
      end
      rcfb_pkg::ST_PIX_WR:  ram_we = 1'b1;
      rcfb_pkg::ST_PIX_RD:  ram_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rcfb_pkg::ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == rcfb_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  // command registers and rectangle walk
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q     <= cmd.operation;
      oob_q    <= oob_now;
      pix_q    <= cmd.pixel_value[PIXEL_BITS-1:0];
      row_up   <= row_up_now;
      col_up   <= col_up_now;
      w_q      <= cmd.rect_width;
      col_left <= is_rect ? cmd.rect_width : CW'(1);
      row_left <= is_rect ? cmd.rect_height : CW'(1);
      x0       <= col_up_now ? CW'(cmd.dest_x) : CW'(cmd.dest_x) + cmd.rect_width - CW'(1);
      sx0      <= col_up_now ? CW'(cmd.src_x) : CW'(cmd.src_x) + cmd.rect_width - CW'(1);
      cur_x    <= col_up_now ? CW'(cmd.dest_x) : CW'(cmd.dest_x) + cmd.rect_width - CW'(1);
      cur_sx   <= col_up_now ? CW'(cmd.src_x) : CW'(cmd.src_x) + cmd.rect_width - CW'(1);
      cur_y    <= row_up_now ? CW'(cmd.dest_y) : CW'(cmd.dest_y) + cmd.rect_height - CW'(1);
      cur_sy   <= row_up_now ? CW'(cmd.src_y) : CW'(cmd.src_y) + cmd.rect_height - CW'(1);
    end else if (step && !last) begin
      if (col_left == CW'(1)) begin
        col_left <= w_q;
        row_left <= row_left - CW'(1);
        cur_x    <= x0;
        cur_sx   <= sx0;
        cur_y    <= row_up ? cur_y + CW'(1) : cur_y - CW'(1);
        cur_sy   <= row_up ? cur_sy + CW'(1) : cur_sy - CW'(1);
      end else begin
        col_left <= col_left - CW'(1);
        cur_x    <= col_up ? cur_x + CW'(1) : cur_x - CW'(1);
        cur_sx   <= col_up ? cur_sx + CW'(1) : cur_sx - CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rcfb_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rcfb_pkg::ST_DONE && out_free) begin
      out_oob   <= oob_q;
      out_value <= (op_q == rcfb_pkg::OP_READ && !oob_q) ? rcfb_pkg::PIX_W'(rd_data) : '0;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.read_value    = out_value;
  assign rsp.out_of_bounds = out_oob;

  rcfb_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

`ifndef SYNTHESIS
  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (32'(ram_waddr) < 32'(DEPTH)))
    else $error("store write address beyond the store");

  a_copy_order: assert property (@(posedge clk) disable iff (rst)
    (state == rcfb_pkg::ST_COPY_WR) |-> ($past(state) == rcfb_pkg::ST_COPY_RD))
    else $error("copy write without a preceding source read");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> ($past(state) == rcfb_pkg::ST_DONE))
    else $error("result raised outside command completion");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == rcfb_pkg::ST_IDLE || state == rcfb_pkg::ST_DONE) |-> (!ram_we && !step))
    else $error("store written while no command is at work");
`endif

endmodule

`default_nettype wire

// File: verif/rect_copy_fill_blitter_chk.sv
`timescale 1ns / 1ps
// checker for the rectangle copy and fill blitter: keeps a shadow pixel store,
// predicts each result from the accepted commands and compares the responses
// depends on rcfb_pkg and the rcfb_cmd_if / rcfb_rsp_if interfaces

module rect_copy_fill_blitter_chk (
  input  logic clk,
  input  logic rst,
  rcfb_cmd_if  cmd,
  rcfb_rsp_if  rsp,
  output int   fail_count,
  output int   open_count
);

  localparam int FB_COLUMNS = 64;
  localparam int FB_ROWS    = 64;
  localparam int PIXEL_BITS = 32;
  localparam int FB_PIXELS  = FB_COLUMNS * FB_ROWS;
  localparam logic [rcfb_pkg::PIX_W-1:0] PIX_MASK = 32'hFFFF_FFFF >> (32 - PIXEL_BITS);

  typedef struct packed {
    logic [rcfb_pkg::PIX_W-1:0] read_value;
    logic                       out_of_bounds;
  } blit_rsp_t;

  logic [rcfb_pkg::PIX_W-1:0] frame      [0:FB_PIXELS-1];
  logic [rcfb_pkg::PIX_W-1:0] frame_snap [0:FB_PIXELS-1];
  blit_rsp_t                  rsp_pending_q [$];
  blit_rsp_t                  rsp_exp;

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  function automatic blit_rsp_t blit_apply(rcfb_pkg::op_t op, int dx, int dy, int sx, int sy,
                                           int w, int h, logic [rcfb_pkg::PIX_W-1:0] pix);
    blit_rsp_t r;
    int        i;
    int        j;
    r.read_value    = '0;
    r.out_of_bounds = 1'b0;
    pix = pix & PIX_MASK;
    case (op)
      rcfb_pkg::OP_FILL: begin
        if (w != 0 && h != 0) begin
          if (dx + w > FB_COLUMNS || dy + h > FB_ROWS) begin
            r.out_of_bounds = 1'b1;
          end else begin
            for (i = 0; i < h; i++)
              for (j = 0; j < w; j++)
                frame[(dy + i) * FB_COLUMNS + dx + j] = pix;
          end
        end
      end
      rcfb_pkg::OP_COPY: begin
        if (w != 0 && h != 0) begin
          if (dx + w > FB_COLUMNS || dy + h > FB_ROWS ||
              sx + w > FB_COLUMNS || sy + h > FB_ROWS) begin
            r.out_of_bounds = 1'b1;
          end else begin
            // copy through a snapshot so overlap cannot corrupt the source
            frame_snap = frame;
            for (i = 0; i < h; i++)
              for (j = 0; j < w; j++)
                frame[(dy + i) * FB_COLUMNS + dx + j] =
                  frame_snap[(sy + i) * FB_COLUMNS + sx + j];
          end
        end
      end
      default: begin
        if (dx >= FB_COLUMNS || dy >= FB_ROWS) begin
          r.out_of_bounds = 1'b1;
        end else if (op == rcfb_pkg::OP_WRITE) begin
          frame[dy * FB_COLUMNS + dx] = pix;
        end else begin
          r.read_value = frame[dy * FB_COLUMNS + dx] & PIX_MASK;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FB_PIXELS; k++) frame[k] = '0;
      rsp_pending_q.delete();
      open_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (rsp_pending_q.size() == 0) begin
          $display("%0t: unexpected response read_value %h out_of_bounds %b",
                   $time, rsp.read_value, rsp.out_of_bounds);
          fail_count++;
        end else begin
          rsp_exp = rsp_pending_q.pop_front();
          if (rsp.read_value !== rsp_exp.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, rsp_exp.read_value, rsp.read_value);
            fail_count++;
          end
          if (rsp.out_of_bounds !== rsp_exp.out_of_bounds) begin
            $display("%0t: out_of_bounds expected %b actual %b",
                     $time, rsp_exp.out_of_bounds, rsp.out_of_bounds);
            fail_count++;
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        rsp_pending_q.push_back(blit_apply(cmd.operation, int'(cmd.dest_x),
                                           int'(cmd.dest_y), int'(cmd.src_x),
                                           int'(cmd.src_y), int'(cmd.rect_width),
                                           int'(cmd.rect_height), cmd.pixel_value));
      end
      open_count = rsp_pending_q.size();
    end
  end

endmodule

// File: verif/rect_copy_fill_blitter_tb.sv
`timescale 1ns / 1ps
// top of the blitter testbench: clock, reset, command stimulus and response stalls
// depends on rcfb_pkg, rcfb_if, rect_copy_fill_blitter and rect_copy_fill_blitter_chk

module rect_copy_fill_blitter_tb;

  logic clk;
  logic rst;
  int   fail_count;
  int   open_count;
  int   idle_pct;
  int   stall_pct;
  int   op_count [4];
  int   last_x;
  int   last_y;

  rcfb_cmd_if cmd_ch ();
  rcfb_rsp_if rsp_ch ();

  rect_copy_fill_blitter u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  rect_copy_fill_blitter_chk u_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_cmd(rcfb_pkg::op_t op, int dx, int dy, int sx, int sy, int w, int h,
                          logic [rcfb_pkg::PIX_W-1:0] pix);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.operation   <= op;
    cmd_ch.dest_x      <= dx[rcfb_pkg::COORD_W-1:0];
    cmd_ch.dest_y      <= dy[rcfb_pkg::COORD_W-1:0];
    cmd_ch.src_x       <= sx[rcfb_pkg::COORD_W-1:0];
    cmd_ch.src_y       <= sy[rcfb_pkg::COORD_W-1:0];
    cmd_ch.rect_width  <= w[rcfb_pkg::SIZE_W-1:0];
    cmd_ch.rect_height <= h[rcfb_pkg::SIZE_W-1:0];
    cmd_ch.pixel_value <= pix;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    op_count[int'(op)]++;
  endtask

  task automatic rand_cmd();
    int            r;
    int            sel;
    rcfb_pkg::op_t op;
    int            w;
    int            h;
    int            dx;
    int            dy;
    int            sx;
    int            sy;
    r   = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    op  = sel < 25 ? rcfb_pkg::OP_FILL :
          sel < 55 ? rcfb_pkg::OP_COPY :
          sel < 75 ? rcfb_pkg::OP_WRITE : rcfb_pkg::OP_READ;
    if (r < 10) begin
      // noise: any field value the ports allow
      send_cmd(rcfb_pkg::op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
               $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
               $urandom_range(0, 127), $urandom_range(0, 127), $urandom());
    end else if (op == rcfb_pkg::OP_FILL || op == rcfb_pkg::OP_COPY) begin
      if ($urandom_range(0, 19) == 0) begin
        w = $urandom_range(33, 64);
        h = $urandom_range(33, 64);
      end else begin
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 8);
      end
      dx = $urandom_range(0, 64 - w);
      dy = $urandom_range(0, 64 - h);
      if ($urandom_range(0, 1) == 0) begin
        sx = dx + $urandom_range(0, 6) - 3;
        sy = dy + $urandom_range(0, 6) - 3;
        sx = sx < 0 ? 0 : sx > 64 - w ? 64 - w : sx;
        sy = sy < 0 ? 0 : sy > 64 - h ? 64 - h : sy;
      end else begin
        sx = $urandom_range(0, 64 - w);
        sy = $urandom_range(0, 64 - h);
      end
      if (r < 13) w = 0;
      last_x = dx;
      last_y = dy;
      send_cmd(op, dx, dy, sx, sy, w, h, $urandom());
    end else begin
      if (op == rcfb_pkg::OP_READ && $urandom_range(0, 1) == 0) begin
        dx = last_x + $urandom_range(0, 3);
        dy = last_y + $urandom_range(0, 3);
        dx = dx > 63 ? 63 : dx;
        dy = dy > 63 ? 63 : dy;
      end else begin
        dx = $urandom_range(0, 63);
        dy = $urandom_range(0, 63);
      end
      if (op == rcfb_pkg::OP_WRITE) begin
        last_x = dx;
        last_y = dy;
      end
      send_cmd(op, dx, dy, $urandom_range(0, 63), $urandom_range(0, 63),
               $urandom_range(0, 127), $urandom_range(0, 127), $urandom());
    end
  endtask

  initial begin
    idle_pct  = 0;
    stall_pct = 0;
    last_x    = 0;
    last_y    = 0;
    foreach (op_count[k]) op_count[k] = 0;
    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.operation   <= rcfb_pkg::OP_FILL;
    cmd_ch.dest_x      <= '0;
    cmd_ch.dest_y      <= '0;
    cmd_ch.src_x       <= '0;
    cmd_ch.src_y       <= '0;
    cmd_ch.rect_width  <= '0;
    cmd_ch.rect_height <= '0;
    cmd_ch.pixel_value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: cleared store, full-store ops, corners, refusals, empty and overlapping
    send_cmd(rcfb_pkg::OP_READ,   0,  0,  0,  0,   0,   0, 32'h0);
    send_cmd(rcfb_pkg::OP_READ,  63, 63, 63, 63, 127, 127, 32'hFFFF_FFFF);
    send_cmd(rcfb_pkg::OP_FILL,   0,  0,  0,  0,  64,  64, 32'hA5A5_5A5A);
    send_cmd(rcfb_pkg::OP_READ,  63, 63,  0,  0,   0,   0, 32'h0);
    send_cmd(rcfb_pkg::OP_WRITE, 63, 63,  0,  0,   0,   0, 32'hFFFF_FFFF);
    send_cmd(rcfb_pkg::OP_WRITE,  0,  0,  0,  0,   0,   0, 32'h0);
    send_cmd(rcfb_pkg::OP_READ,  63, 63,  0,  0,   0,   0, 32'h0);
    send_cmd(rcfb_pkg::OP_READ,   0,  0,  0,  0,   0,   0, 32'h0);
    send_cmd(rcfb_pkg::OP_FILL,  63,  0,  0,  0,   2,   1, 32'h1111_1111);
    send_cmd(rcfb_pkg::OP_FILL,   0, 63,  0,  0,   1,   2, 32'h2222_2222);
    send_cmd(rcfb_pkg::OP_FILL,  63, 63,  0,  0, 127, 127, 32'h3333_3333);
    send_cmd(rcfb_pkg::OP_FILL,  63, 63,  0,  0,   0, 127, 32'h4444_4444);
    send_cmd(rcfb_pkg::OP_COPY,  63, 63, 63, 63, 127,   0, 32'h0);
    send_cmd(rcfb_pkg::OP_FILL,  10, 10,  0,  0,   8,   8, 32'h1234_5678);
    send_cmd(rcfb_pkg::OP_WRITE, 10, 10,  0,  0,   0,   0, 32'hDEAD_BEEF);
    send_cmd(rcfb_pkg::OP_COPY,  12, 13, 10, 10,   8,   8, 32'h0);
    send_cmd(rcfb_pkg::OP_READ,  12, 13,  0,  0,   0,   0, 32'h0);
    send_cmd(rcfb_pkg::OP_COPY,   9,  8, 12, 13,   8,   8, 32'h0);
    send_cmd(rcfb_pkg::OP_READ,   9,  8,  0,  0,   0,   0, 32'h0);
    send_cmd(rcfb_pkg::OP_READ,  14, 14,  0,  0,   0,   0, 32'h0);
    send_cmd(rcfb_pkg::OP_COPY,   0,  0, 60,  0,   8,   1, 32'h0);
    send_cmd(rcfb_pkg::OP_COPY,  60,  0,  0,  0,   8,   1, 32'h0);
    send_cmd(rcfb_pkg::OP_COPY,   0,  0,  0,  0,  64,  64, 32'h0);
    send_cmd(rcfb_pkg::OP_FILL,  63, 63,  0,  0,   1,   1, 32'h0000_0001);
    send_cmd(rcfb_pkg::OP_READ,  63, 63,  0,  0,   0,   0, 32'h0);

    // random: no idling, sender idle, receiver stall, then both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = ph == 1 ? 56 : ph == 3 ? 34 : 0;
      stall_pct = ph == 2 ? 56 : ph == 3 ? 34 : 0;
      repeat (19) rand_cmd();
    end
    cmd_ch.valid <= 1'b0;

    @(negedge clk);
    while (open_count != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("ran %0d commands: fill %0d, copy %0d, write %0d, read %0d",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("directed corners, refusals and overlaps, then random under four idle patterns");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rcfb_pkg.sv
sv/rcfb_if.sv
sv/rcfb_ram.sv
sv/rect_copy_fill_blitter.sv
verif/rect_copy_fill_blitter_chk.sv
verif/rect_copy_fill_blitter_tb.sv
